### sv/iodp_pkg.sv
// iodp_pkg: shared constants, types and helpers for the I/O board dual-port RAM.
// Used by iodp_scale and io_board_dpram_lightgun; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package iodp_pkg;

  // Shared RAM geometry
  localparam int MEM_DEPTH = 4096;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  // Fixed byte locations in the shared RAM
  localparam logic [15:0] CMD_ADDR    = 16'h0020;
  localparam logic [15:0] STATUS_ADDR = 16'h0021;
  localparam logic [15:0] GUN_ADDR    = 16'h0080;
  localparam logic [15:0] FLAG_ADDR   = 16'h0088;
  localparam logic [7:0]  STATUS_INIT = 8'h40;
  localparam logic [7:0]  FLAGS_INIT  = 8'hFC;

  // Gun calibration window and border margins
  localparam int SIZE_W  = 16;
  localparam int COORD_W = 10;
  localparam int SPAN_W  = 9;
  localparam int PROD_W  = SIZE_W + SPAN_W;
  localparam int CNT_W   = $clog2(PROD_W);

  localparam logic [COORD_W-1:0] X_LO = 10'h083;
  localparam logic [COORD_W-1:0] X_HI = 10'h276;
  localparam logic [COORD_W-1:0] Y_LO = 10'h024;
  localparam logic [COORD_W-1:0] Y_HI = 10'h1A9;
  localparam logic [SPAN_W-1:0]  X_SPAN = SPAN_W'(X_HI - X_LO);
  localparam logic [SPAN_W-1:0]  Y_SPAN = SPAN_W'(Y_HI - Y_LO);
  localparam logic [COORD_W-1:0] X_MARGIN = 10'd24;
  localparam logic [COORD_W-1:0] Y_MARGIN = 10'd19;

  // Item modes
  typedef enum logic [2:0] {
    MODE_READ     = 3'd0,
    MODE_WRITE    = 3'd1,
    MODE_SET_PORT = 3'd2,
    MODE_SET_GUN  = 3'd3,
    MODE_PUBLISH  = 3'd4
  } mode_t;

  // Configuration register indexes
  localparam logic REG_SCREEN_W = 1'b0;
  localparam logic REG_SCREEN_H = 1'b1;

  // Request to and response from the coordinate scaler
  typedef struct packed {
    logic               start;
    logic [SIZE_W-1:0]  v;
    logic [SIZE_W-1:0]  size;
    logic [COORD_W-1:0] lo;
    logic [SPAN_W-1:0]  span;
  } scale_req_t;

  typedef struct packed {
    logic               done;
    logic [COORD_W-1:0] value;
  } scale_rsp_t;

  // RAM location that each input port byte is copied to
  function automatic logic [ADDR_W-1:0] port_addr(input logic [1:0] idx);
    logic [ADDR_W-1:0] a;
    case (idx)
      2'd0:    a = ADDR_W'(8'h08);
      2'd1:    a = ADDR_W'(8'h09);
      2'd2:    a = ADDR_W'(8'h0A);
      default: a = ADDR_W'(8'h11);
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

### sv/iodp_ram.sv
// iodp_ram: generic single-write, single-read synchronous RAM, registered read.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module iodp_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### sv/iodp_scale.sv
// iodp_scale: clamps a gun coordinate, multiplies by the window span and divides
// by (screen size - 1) with a bit-serial restoring divider. Uses iodp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module iodp_scale (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire iodp_pkg::scale_req_t req,
  output iodp_pkg::scale_rsp_t    rsp
);

  import iodp_pkg::*;

  typedef enum logic [1:0] {
    SC_IDLE,
    SC_MUL,
    SC_DIV,
    SC_FIN
  } sc_state_t;

  sc_state_t            state_r;
  logic [SIZE_W-1:0]    vc_r;
  logic [SIZE_W-1:0]    div_r;
  logic [COORD_W-1:0]   lo_r;
  logic [SPAN_W-1:0]    span_r;
  logic [PROD_W-1:0]    dvd_r;
  logic [SIZE_W-1:0]    rem_r;
  logic [SPAN_W-1:0]    quo_r;
  logic [CNT_W-1:0]     cnt_r;

  logic [SIZE_W:0]      rem_sh;
  logic [SIZE_W:0]      diff;

  // one restoring step: bring down the next dividend bit, try the subtract
  always_comb begin
    rem_sh = {rem_r, dvd_r[PROD_W-1]};
    diff   = rem_sh - {1'b0, div_r};
  end

  // sequencer: clamp, multiply, PROD_W divide steps, finish
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SC_IDLE;
    end else begin
      case (state_r)
        SC_IDLE: begin
          if (req.start) begin
            lo_r   <= req.lo;
            span_r <= req.span;
            div_r  <= req.size - SIZE_W'(1);
            vc_r   <= (req.v >= req.size) ? req.size - SIZE_W'(1) : req.v;
            quo_r  <= '0;
            // screen size of zero or one gives the window minimum
            state_r <= (req.size <= SIZE_W'(1)) ? SC_FIN : SC_MUL;
          end
        end
        SC_MUL: begin
          // full-width product of the clamped coordinate and the span
          dvd_r   <= PROD_W'(vc_r) * PROD_W'(span_r);
          rem_r   <= '0;
          cnt_r   <= '0;
          state_r <= SC_DIV;
        end
        SC_DIV: begin
          dvd_r <= {dvd_r[PROD_W-2:0], 1'b0};
          if (!diff[SIZE_W]) begin
            rem_r <= diff[SIZE_W-1:0];
            quo_r <= {quo_r[SPAN_W-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh[SIZE_W-1:0];
            quo_r <= {quo_r[SPAN_W-2:0], 1'b0};
          end
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(PROD_W - 1)) begin
            state_r <= SC_FIN;
          end
        end
        SC_FIN: begin
          state_r <= SC_IDLE;
        end
        default: begin
          state_r <= SC_IDLE;
        end
      endcase
    end
  end

  // quotient never exceeds the span, so the sum stays inside the window
  assign rsp.done  = (state_r == SC_FIN);
  assign rsp.value = lo_r + COORD_W'(quo_r);

endmodule

`default_nettype wire

### sv/io_board_dpram_lightgun.sv
// io_board_dpram_lightgun: top level of the I/O board shared byte RAM with
// input ports and two light guns. Uses iodp_pkg, iodp_ram and iodp_scale.
//
//  channel | signals                                    | dir
//  --------+--------------------------------------------+-----
//  in      | in_valid/in_ready, mode offset data index   | in
//          | gun_x gun_y off_screen                      |
//  out     | out_valid/out_ready, out_read_data          | out
//  cfg     | cfg_we, cfg_index, cfg_wdata                | in
//
// Read, write, set-port, set-gun and unused modes go from idle to the post state,
// where the result enters the output register; the RAM read port's registered
// data supplies it for reads. Publish makes 4 port copies, four coordinate
// scalings in the shared bit-serial divider (a screen size of 0 or 1 skips the
// multiply and divide), then 9 gun and flag writes.
// After reset a clearing pass writes all MEM_DEPTH (4096) locations; no input
// beat is taken until it ends. A stalled result sits in the output register
// while the next beat is accepted.
`timescale 1ns / 1ps
`default_nettype none

module io_board_dpram_lightgun (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_mode,
  input  wire logic [15:0] in_offset,
  input  wire logic [7:0]  in_data,
  input  wire logic [1:0]  in_index,
  input  wire logic [15:0] in_gun_x,
  input  wire logic [15:0] in_gun_y,
  input  wire logic        in_off_screen,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_read_data,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  import iodp_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PORT,
    S_SCALE,
    S_WAIT,
    S_GUN,
    S_FLAG,
    S_POST
  } state_t;

  state_t               state_r;
  logic [ADDR_W-1:0]    clr_addr_r;
  logic [1:0]           pub_cnt_r;
  logic                 player_r;
  logic                 axis_r;
  logic [7:0]           flags_r;
  logic [COORD_W-1:0]   gx_r;
  logic [COORD_W-1:0]   gy_r;
  logic [7:0]           res_r;
  logic                 res_ram_r;
  logic                 out_valid_r;
  logic [7:0]           out_data_r;
  logic [SIZE_W-1:0]    screen_w_r;
  logic [SIZE_W-1:0]    screen_h_r;
  logic [7:0]           input_r [4];
  logic [SIZE_W-1:0]    gun_x_r [2];
  logic [SIZE_W-1:0]    gun_y_r [2];
  logic                 gun_off_r [2];

  logic                 accept;
  logic                 in_range;
  mode_t                mode;
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [7:0]           ram_wdata;
  logic                 ram_re;
  logic [7:0]           ram_rdata;
  scale_req_t           sreq;
  scale_rsp_t           srsp;
  logic [COORD_W-1:0]   gx_eff;
  logic [COORD_W-1:0]   gy_eff;
  logic                 near_edge;
  logic                 post_load;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign mode      = mode_t'(in_mode);
  assign in_range  = ({1'b0, in_offset} < 17'(MEM_DEPTH));
  assign out_valid = out_valid_r;
  assign out_read_data = out_data_r;
  assign post_load = (state_r == S_POST) && (!out_valid_r || out_ready);

  // shared RAM
  iodp_ram #(
    .DEPTH (MEM_DEPTH),
    .WIDTH (8)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (in_offset[ADDR_W-1:0]),
    .rd_data (ram_rdata)
  );

  // coordinate scaler, shared by both axes and both players
  always_comb begin
    sreq.start = (state_r == S_SCALE);
    if (axis_r) begin
      sreq.v    = gun_x_r[player_r];
      sreq.size = screen_w_r;
      sreq.lo   = X_LO;
      sreq.span = X_SPAN;
    end else begin
      sreq.v    = gun_y_r[player_r];
      sreq.size = screen_h_r;
      sreq.lo   = Y_LO;
      sreq.span = Y_SPAN;
    end
  end

  iodp_scale u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sreq),
    .rsp   (srsp)
  );

  // forced-off guns sit at the window minimum; border test on final values
  always_comb begin
    gx_eff = gun_off_r[player_r] ? X_LO : gx_r;
    gy_eff = gun_off_r[player_r] ? Y_LO : gy_r;
    near_edge = (gx_eff <= X_LO + X_MARGIN) || (gx_eff >= X_HI - X_MARGIN) ||
                (gy_eff <= Y_LO + Y_MARGIN) || (gy_eff >= Y_HI - Y_MARGIN);
  end

  // RAM port steering: clearing pass, game-side write, publish writes
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_addr_r;
    ram_wdata = 8'hFF;
    ram_re    = accept && (mode == MODE_READ) && in_range;
    case (state_r)
      S_CLEAR: begin
        ram_we = 1'b1;
        if (clr_addr_r == ADDR_W'(CMD_ADDR)) begin
          ram_wdata = 8'h00;
        end else if (clr_addr_r == ADDR_W'(STATUS_ADDR)) begin
          ram_wdata = STATUS_INIT;
        end
      end
      S_IDLE: begin
        ram_we    = accept && (mode == MODE_WRITE) && in_range;
        ram_waddr = in_offset[ADDR_W-1:0];
        // a nonzero command is acknowledged at once
        ram_wdata = ((in_offset == CMD_ADDR) && (in_data != 8'h00)) ? 8'h00 : in_data;
      end
      S_PORT: begin
        ram_we    = 1'b1;
        ram_waddr = port_addr(pub_cnt_r);
        ram_wdata = input_r[pub_cnt_r];
      end
      S_GUN: begin
        ram_we    = 1'b1;
        ram_waddr = ADDR_W'(GUN_ADDR) + ADDR_W'({player_r, pub_cnt_r});
        case (pub_cnt_r)
          2'd0:    ram_wdata = gy_eff[7:0];
          2'd1:    ram_wdata = 8'(gy_eff[COORD_W-1:8]);
          2'd2:    ram_wdata = gx_eff[7:0];
          default: ram_wdata = 8'(gx_eff[COORD_W-1:8]);
        endcase
      end
      S_FLAG: begin
        ram_we    = 1'b1;
        ram_waddr = ADDR_W'(FLAG_ADDR);
        ram_wdata = flags_r;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_w_r <= 16'd496;
      screen_h_r <= 16'd384;
    end else if (cfg_we) begin
      if (cfg_index == REG_SCREEN_W) begin
        screen_w_r <= cfg_wdata;
      end else begin
        screen_h_r <= cfg_wdata;
      end
    end
  end

  // main sequencer with output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        input_r[i] <= 8'hFF;
      end
      for (int i = 0; i < 2; i++) begin
        gun_x_r[i]   <= '0;
        gun_y_r[i]   <= '0;
        gun_off_r[i] <= 1'b0;
      end
    end else begin
      // a taken result beat frees the register unless a new one lands
      if (out_valid_r && out_ready && !post_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + ADDR_W'(1);
          if (clr_addr_r == ADDR_W'(MEM_DEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            // reads answer from the RAM, or 0xFF out of range; all else 0
            res_r     <= (mode == MODE_READ) ? 8'hFF : 8'h00;
            res_ram_r <= (mode == MODE_READ) && in_range;
            state_r   <= (mode == MODE_PUBLISH) ? S_PORT : S_POST;
            case (mode)
              MODE_SET_PORT: begin
                input_r[in_index] <= in_data;
              end
              MODE_SET_GUN: begin
                if (!in_index[1]) begin
                  gun_x_r[in_index[0]]   <= in_gun_x;
                  gun_y_r[in_index[0]]   <= in_gun_y;
                  gun_off_r[in_index[0]] <= in_off_screen;
                end
              end
              MODE_PUBLISH: begin
                pub_cnt_r <= '0;
                player_r  <= 1'b0;
                axis_r    <= 1'b0;
                flags_r   <= FLAGS_INIT;
              end
              default: begin
              end
            endcase
          end
        end
        S_PORT: begin
          pub_cnt_r <= pub_cnt_r + 2'd1;
          if (pub_cnt_r == 2'd3) begin
            state_r <= S_SCALE;
          end
        end
        S_SCALE: begin
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (srsp.done) begin
            if (!axis_r) begin
              gy_r    <= srsp.value;
              axis_r  <= 1'b1;
              state_r <= S_SCALE;
            end else begin
              gx_r      <= srsp.value;
              pub_cnt_r <= '0;
              state_r   <= S_GUN;
            end
          end
        end
        S_GUN: begin
          pub_cnt_r <= pub_cnt_r + 2'd1;
          if (pub_cnt_r == 2'd3) begin
            // forced-off guns always land on the border
            if (near_edge) begin
              if (player_r) begin
                flags_r[1] <= 1'b1;
              end else begin
                flags_r[0] <= 1'b1;
              end
            end
            if (player_r) begin
              state_r <= S_FLAG;
            end else begin
              player_r <= 1'b1;
              axis_r   <= 1'b0;
              state_r  <= S_SCALE;
            end
          end
        end
        S_FLAG: begin
          res_r     <= 8'h00;
          res_ram_r <= 1'b0;
          state_r   <= S_POST;
        end
        S_POST: begin
          if (post_load) begin
            out_valid_r <= 1'b1;
            out_data_r  <= res_ram_r ? ram_rdata : res_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### sv/iodp_checker.sv
// iodp_checker: port-level checks on io_board_dpram_lightgun, bound to the top.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module iodp_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_read_data
);

  // reset empties the result register
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat valid straight after reset");

  // the clearing pass holds off input beats after reset
  a_reset_in: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input taken during RAM clearing pass");

  // one item at a time: ready drops after every accepted beat
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat accepted while an item is in work");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data))
    else $error("stalled result beat changed or dropped");

endmodule

bind io_board_dpram_lightgun iodp_checker u_iodp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_read_data (out_read_data)
);

`default_nettype wire
